// ===== design/eilt_pkg.sv =====
`timescale 1ns / 1ps
package eilt_pkg;
    localparam int SLOTS_DEF = 16;
    localparam logic [31:0] IDLE_DEF = 32'd30;
    localparam logic [31:0] FREEZE_DEF = 32'd300;
    localparam logic [31:0] DISCARD_DEF = 32'd3000;
    localparam logic [31:0] RELOAD_SIZE = 32'd4096;

    typedef enum logic [3:0] {
        CMD_OPEN = 4'd0, CMD_CLOSE = 4'd1, CMD_QUERY = 4'd2, CMD_TICK = 4'd3,
        CMD_FOCUS = 4'd4, CMD_BLUR = 4'd5, CMD_CRASH = 4'd6, CMD_RELOAD = 4'd7,
        CMD_DISCARD = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        LIFE_ACTIVE = 3'd0, LIFE_IDLE = 3'd1, LIFE_FROZEN = 3'd2,
        LIFE_DISCARDED = 3'd3, LIFE_CRASHED = 3'd4
    } life_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_INVALID = 3'd1, ST_NOSPACE = 3'd2,
        ST_NOTFOUND = 3'd3, ST_BADSTATE = 3'd4
    } status_t;

    localparam int C_OPENED = 0;
    localparam int C_CLOSED = 1;
    localparam int C_DISCARDS = 2;
    localparam int C_FREEZES = 3;
    localparam int C_RELOADS = 4;
    localparam int C_CRASHES = 5;
    localparam int C_RECOVERIES = 6;
    localparam int NSTATS = 7;

    localparam logic [1:0] REG_IDLE = 2'd0;
    localparam logic [1:0] REG_FREEZE = 2'd1;
    localparam logic [1:0] REG_DISCARD = 2'd2;

    typedef enum logic [2:0] {
        FSM_IDLE, FSM_SCAN, FSM_WAIT, FSM_FETCH, FSM_AGE, FSM_READ
    } fsm_t;

    // One slot record as kept in the memory.
    typedef struct packed {
        logic        used;
        logic [31:0] id;
        logic [2:0]  life;
        logic [63:0] focus_time;
        logic [31:0] content;
        logic        doc;
        logic        crashed_ever;
    } slot_t;
endpackage

// ===== design/entry_idle_ladder_table.sv =====
`timescale 1ns / 1ps
// Channel   Signals                                       Direction
// command   start, busy, cmd, tab_id, content_size_in,    in
//           now_tick, stat_select
// result    done, status .. stat_value                    out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     in
//
// For each command, one pass reads every slot through the single read port of the
// slot memory, then the chosen slot is read again, its age is registered, and it
// is modified and written back. done comes in the cycle after, with busy low.
// Reset clears the control registers and marks all slots unwritten; no clearing pass.
// done is high for one cycle; the receiver cannot stall it.
module entry_idle_ladder_table #(
    parameter int SLOTS = eilt_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] tab_id,
    input  logic [31:0] content_size_in,
    input  logic [63:0] now_tick,
    input  logic [2:0]  stat_select,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] new_id,
    output logic [2:0]  tab_state,
    output logic [31:0] content_size,
    output logic        doc_loaded,
    output logic [31:0] focused_id,
    output logic [4:0]  open_count,
    output logic [31:0] stat_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import eilt_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    fsm_t state_reg, state_next;
    logic [3:0]  cmd_reg;
    logic [31:0] id_reg, size_reg;
    logic [63:0] now_reg;
    logic [2:0]  sel_reg;
    logic [31:0] thr_i_reg, thr_f_reg, thr_d_reg;
    logic [63:0] time_reg;
    logic [31:0] focus_reg, focus_next;
    logic [CW-1:0] used_reg, used_next;
    logic [31:0] stats_reg [NSTATS];
    logic [AW:0] scan_reg;
    logic [AW:0] rcnt_reg;
    logic found_reg, free_ok_reg;
    logic [AW-1:0] hit_reg, free_reg;
    logic [31:0] top_reg;
    logic [63:0] span_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] slot_sel;
    slot_t rd_data, wr_data;
    logic wr_en;

    logic done_reg;
    logic [2:0] status_reg;
    logic [31:0] new_id_reg, content_reg, stat_reg;
    logic [2:0] life_reg;
    logic doc_reg;

    eilt_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
        .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(slot_sel), .wr_data(wr_data)
    );

    // Timing for events: the scan entry is read in the cycle after its address.
    logic is_open, is_event, time_bad;
    assign is_open = (cmd_reg == CMD_OPEN);
    assign is_event = !(cmd_reg == CMD_OPEN || cmd_reg == CMD_CLOSE || cmd_reg == CMD_QUERY);
    assign time_bad = is_event && (now_reg < time_reg);

    // An open works on the first free slot, every other command on the matching one.
    assign slot_sel = is_open ? free_reg : hit_reg;

    assign busy = (state_reg != FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign rd_addr = (state_reg == FSM_SCAN) ? scan_reg[AW-1:0] : slot_sel;

    // Effective thresholds.
    logic [31:0] ti, tf, td;
    always_comb
    begin
        ti = (thr_i_reg != '0) ? thr_i_reg : IDLE_DEF;
        tf = (thr_f_reg != '0) ? thr_f_reg : FREEZE_DEF;
        td = (thr_d_reg != '0) ? thr_d_reg : DISCARD_DEF;
        if (tf < ti)
        begin
            tf = ti;
        end
        if (td < tf)
        begin
            td = tf;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result of the read-modify-write step.
    slot_t       s_new;
    status_t     st;
    logic        have_slot, do_wr;
    logic [31:0] made;
    logic [NSTATS-1:0] inc;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (start) state_next = FSM_SCAN;
            FSM_SCAN:  if (scan_reg == (AW+1)'(SLOTS - 1)) state_next = FSM_WAIT;
            FSM_WAIT:  state_next = FSM_FETCH;
            FSM_FETCH: state_next = FSM_AGE;
            FSM_AGE:   state_next = FSM_READ;
            FSM_READ:  state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        s_new = rd_data;
        st = ST_OK;
        have_slot = 1'b0;
        do_wr = 1'b0;
        made = '0;
        inc = '0;
        focus_next = focus_reg;
        used_next = used_reg;
        if (is_open)
        begin
            if (used_reg >= CW'(SLOTS) || !free_ok_reg || top_reg == 32'hFFFF_FFFF)
            begin
                st = ST_NOSPACE;
            end
            else
            begin
                s_new.used = 1'b1;
                s_new.id = top_reg + 32'd1;
                s_new.life = LIFE_ACTIVE;
                s_new.focus_time = time_reg;
                s_new.content = size_reg;
                s_new.doc = 1'b1;
                do_wr = 1'b1;
                have_slot = 1'b1;
                made = top_reg + 32'd1;
                focus_next = top_reg + 32'd1;
                used_next = used_reg + CW'(1);
                inc[C_OPENED] = 1'b1;
            end
        end
        else if (!is_event)
        begin
            if (!found_reg)
            begin
                st = ST_NOTFOUND;
            end
            else if (cmd_reg == CMD_CLOSE)
            begin
                if (focus_reg == id_reg) focus_next = '0;
                s_new.used = 1'b0;
                s_new.id = '0;
                do_wr = 1'b1;
                used_next = used_reg - CW'(1);
                inc[C_CLOSED] = 1'b1;
            end
            else
            begin
                have_slot = 1'b1;
            end
        end
        else if (time_bad)
        begin
            st = ST_INVALID;
        end
        else if (!found_reg)
        begin
            st = ST_NOTFOUND;
        end
        else
        begin
            have_slot = 1'b1;
            do_wr = 1'b1;
            case (cmd_reg)
                CMD_TICK:
                begin
                    if (rd_data.life != LIFE_CRASHED && rd_data.life != LIFE_DISCARDED)
                    begin
                        if (span_reg >= {32'd0, td})
                        begin
                            if (rd_data.doc)
                            begin
                                s_new.doc = 1'b0;
                                s_new.content = '0;
                                inc[C_DISCARDS] = 1'b1;
                            end
                            s_new.life = LIFE_DISCARDED;
                        end
                        else if (span_reg >= {32'd0, tf})
                        begin
                            if (rd_data.life != LIFE_FROZEN)
                            begin
                                s_new.life = LIFE_FROZEN;
                                inc[C_FREEZES] = 1'b1;
                            end
                        end
                        else if (span_reg >= {32'd0, ti} && rd_data.life == LIFE_ACTIVE)
                        begin
                            s_new.life = LIFE_IDLE;
                        end
                    end
                end
                CMD_FOCUS:
                begin
                    if (rd_data.life == LIFE_CRASHED)
                    begin
                        st = ST_BADSTATE;
                    end
                    else
                    begin
                        if (rd_data.life == LIFE_DISCARDED)
                        begin
                            s_new.doc = 1'b1;
                            if (rd_data.content == '0) s_new.content = RELOAD_SIZE;
                            inc[C_RELOADS] = 1'b1;
                        end
                        s_new.life = LIFE_ACTIVE;
                        s_new.focus_time = now_reg;
                        focus_next = id_reg;
                    end
                end
                CMD_BLUR:
                begin
                    if (focus_reg == id_reg) focus_next = '0;
                end
                CMD_CRASH:
                begin
                    if (rd_data.life == LIFE_CRASHED)
                    begin
                        st = ST_BADSTATE;
                    end
                    else
                    begin
                        s_new.life = LIFE_CRASHED;
                        s_new.crashed_ever = 1'b1;
                        inc[C_CRASHES] = 1'b1;
                        if (focus_reg == id_reg) focus_next = '0;
                    end
                end
                CMD_RELOAD:
                begin
                    if (rd_data.life != LIFE_CRASHED && rd_data.life != LIFE_DISCARDED)
                    begin
                        st = ST_INVALID;
                    end
                    else
                    begin
                        s_new.life = LIFE_ACTIVE;
                        s_new.doc = 1'b1;
                        if (rd_data.content == '0) s_new.content = RELOAD_SIZE;
                        s_new.focus_time = now_reg;
                        inc[C_RELOADS] = 1'b1;
                        if (rd_data.crashed_ever) inc[C_RECOVERIES] = 1'b1;
                        focus_next = id_reg;
                    end
                end
                CMD_DISCARD:
                begin
                    if (rd_data.life == LIFE_CRASHED)
                    begin
                        st = ST_BADSTATE;
                    end
                    else
                    begin
                        if (rd_data.doc)
                        begin
                            s_new.doc = 1'b0;
                            s_new.content = '0;
                            inc[C_DISCARDS] = 1'b1;
                        end
                        s_new.life = LIFE_DISCARDED;
                    end
                end
                default: st = ST_INVALID;
            endcase
        end
    end

    assign wr_en = (state_reg == FSM_READ) && do_wr;
    assign wr_data = s_new;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            thr_i_reg <= '0;
            thr_f_reg <= '0;
            thr_d_reg <= '0;
            time_reg <= '0;
            focus_reg <= '0;
            used_reg <= '0;
            for (int k = 0; k < NSTATS; k++) stats_reg[k] <= '0;
            scan_reg <= '0;
            rcnt_reg <= '0;
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            hit_reg <= '0;
            free_reg <= '0;
            top_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IDLE:    thr_i_reg <= cfg_data;
                    REG_FREEZE:  thr_f_reg <= cfg_data;
                    REG_DISCARD: thr_d_reg <= cfg_data;
                    default:     ;
                endcase
            end
            case (state_reg)
                FSM_IDLE:
                begin
                    if (start)
                    begin
                        scan_reg <= '0;
                        rcnt_reg <= '0;
                        found_reg <= 1'b0;
                        free_ok_reg <= 1'b0;
                        top_reg <= '0;
                    end
                end
                FSM_SCAN, FSM_WAIT:
                begin
                    if (state_reg == FSM_SCAN) scan_reg <= scan_reg + (AW+1)'(1);
                    // Data for slot rcnt arrives in the cycle after its address.
                    if (state_reg == FSM_WAIT || scan_reg != '0)
                    begin
                        rcnt_reg <= rcnt_reg + (AW+1)'(1);
                        if (!rd_data.used)
                        begin
                            if (!free_ok_reg)
                            begin
                                free_ok_reg <= 1'b1;
                                free_reg <= rcnt_reg[AW-1:0];
                            end
                        end
                        else
                        begin
                            if (rd_data.id > top_reg) top_reg <= rd_data.id;
                            if (!found_reg && id_reg != '0 && rd_data.id == id_reg)
                            begin
                                found_reg <= 1'b1;
                                hit_reg <= rcnt_reg[AW-1:0];
                            end
                        end
                    end
                    if (state_reg == FSM_WAIT)
                    begin
                        if (is_event && !time_bad) time_reg <= now_reg;
                    end
                end
                FSM_READ:
                begin
                    focus_reg <= focus_next;
                    used_reg <= used_next;
                    for (int k = 0; k < NSTATS; k++)
                        if (inc[k]) stats_reg[k] <= stats_reg[k] + 32'd1;
                    done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Last slot's data is judged in FSM_WAIT; span uses the time already updated.
    always_ff @(posedge clk) begin
        if (state_reg == FSM_IDLE && start)
        begin
            cmd_reg <= cmd;
            id_reg <= tab_id;
            size_reg <= content_size_in;
            now_reg <= now_tick;
            sel_reg <= stat_select;
        end
        if (state_reg == FSM_AGE)
        begin
            span_reg <= time_reg - rd_data.focus_time;
        end
        if (state_reg == FSM_READ)
        begin
            status_reg <= st;
            new_id_reg <= made;
            life_reg <= have_slot ? s_new.life : 3'd0;
            content_reg <= have_slot ? s_new.content : '0;
            doc_reg <= have_slot && s_new.doc;
        end
    end

    always_comb
    begin
        stat_reg = (sel_reg < 3'(NSTATS)) ? stats_reg[sel_reg] : '0;
    end

    assign done = done_reg;
    assign status = status_reg;
    assign new_id = new_id_reg;
    assign tab_state = life_reg;
    assign content_size = content_reg;
    assign doc_loaded = doc_reg;
    assign focused_id = focus_reg;
    assign open_count = 5'(used_reg);
    assign stat_value = stat_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(SLOTS)) else $error("slot count overflow");
`endif
endmodule

// ===== design/eilt_mem.sv =====
`timescale 1ns / 1ps
module eilt_mem #(
    parameter int SLOTS = eilt_pkg::SLOTS_DEF,
    parameter int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [AW-1:0]        rd_addr,
    output eilt_pkg::slot_t      rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  eilt_pkg::slot_t      wr_data
);
    import eilt_pkg::*;

    slot_t mem [SLOTS];
    slot_t rd_q_reg;
    logic [SLOTS-1:0] valid_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    // Entries never written since reset read as all zero.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;
endmodule

// ===== verif/eilt_checker.sv =====
`timescale 1ns / 1ps
module eilt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] tab_id,
    input  logic [31:0] content_size_in,
    input  logic [63:0] now_tick,
    input  logic [2:0]  stat_select,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [31:0] new_id,
    input  logic [2:0]  tab_state,
    input  logic [31:0] content_size,
    input  logic        doc_loaded,
    input  logic [31:0] focused_id,
    input  logic [4:0]  open_count,
    input  logic [31:0] stat_value,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import eilt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] new_id;
        logic [2:0]  tab_state;
        logic [31:0] content_size;
        logic        doc_loaded;
        logic [31:0] focused_id;
        logic [4:0]  open_count;
        logic [31:0] stat_value;
    } answer_t;

    answer_t answers_due[$];

    logic [31:0] thr_idle, thr_freeze, thr_discard;
    logic        t_used[SLOTS_DEF];
    logic [31:0] t_id[SLOTS_DEF];
    life_t       t_life[SLOTS_DEF];
    logic [63:0] t_focus[SLOTS_DEF];
    logic [31:0] t_content[SLOTS_DEF];
    logic        t_doc[SLOTS_DEF];
    logic        t_crashed[SLOTS_DEF];
    logic [63:0] clock_now;
    logic [31:0] focus_holder;
    logic [4:0]  in_use;
    logic [31:0] counters[NSTATS];

    assign pending = answers_due.size();

    function automatic int find_entry(logic [31:0] id);
        if (id == 0)
            return -1;
        for (int i = 0; i < SLOTS_DEF; i++)
            if (t_used[i] && t_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void drop_doc(int s);
        if (t_doc[s])
        begin
            t_doc[s] = 1'b0;
            t_content[s] = 0;
            counters[C_DISCARDS]++;
        end
        t_life[s] = LIFE_DISCARDED;
    endfunction

    function automatic void age_entry(int s);
        logic [31:0] ti, tf, td;
        logic [63:0] span;
        ti = (thr_idle != 0) ? thr_idle : IDLE_DEF;
        tf = (thr_freeze != 0) ? thr_freeze : FREEZE_DEF;
        td = (thr_discard != 0) ? thr_discard : DISCARD_DEF;
        span = clock_now - t_focus[s];
        if (tf < ti)
            tf = ti;
        if (td < tf)
            td = tf;
        if (t_life[s] == LIFE_CRASHED || t_life[s] == LIFE_DISCARDED)
            return;
        if (span >= {32'd0, td})
            drop_doc(s);
        else if (span >= {32'd0, tf})
        begin
            if (t_life[s] != LIFE_FROZEN)
            begin
                t_life[s] = LIFE_FROZEN;
                counters[C_FREEZES]++;
            end
        end
        else if (span >= {32'd0, ti} && t_life[s] == LIFE_ACTIVE)
            t_life[s] = LIFE_IDLE;
    endfunction

    function automatic answer_t run_command(logic [3:0] c, logic [31:0] id,
                                            logic [31:0] size, logic [63:0] now,
                                            logic [2:0] sel);
        answer_t a;
        int s, free_slot;
        logic [31:0] top;
        status_t st;
        s = -1;
        a = '0;
        if (c == CMD_OPEN)
        begin
            free_slot = -1;
            top = 0;
            st = ST_OK;
            if (in_use >= SLOTS_DEF)
                st = ST_NOSPACE;
            else
            begin
                for (int i = 0; i < SLOTS_DEF; i++)
                    if (!t_used[i])
                    begin
                        if (free_slot < 0)
                            free_slot = i;
                    end
                    else if (t_id[i] > top)
                        top = t_id[i];
                if (free_slot < 0 || top == 32'hFFFF_FFFF)
                    st = ST_NOSPACE;
                else
                begin
                    t_used[free_slot] = 1'b1;
                    t_id[free_slot] = top + 1;
                    t_life[free_slot] = LIFE_ACTIVE;
                    t_focus[free_slot] = clock_now;
                    t_content[free_slot] = size;
                    t_doc[free_slot] = 1'b1;
                    in_use++;
                    counters[C_OPENED]++;
                    focus_holder = top + 1;
                    a.new_id = top + 1;
                    s = free_slot;
                end
            end
        end
        else if (c == CMD_CLOSE || c == CMD_QUERY)
        begin
            s = find_entry(id);
            if (s < 0)
                st = ST_NOTFOUND;
            else
            begin
                st = ST_OK;
                if (c == CMD_CLOSE)
                begin
                    if (focus_holder == id)
                        focus_holder = 0;
                    t_used[s] = 1'b0;
                    t_id[s] = 0;
                    in_use--;
                    counters[C_CLOSED]++;
                    s = -1;
                end
            end
        end
        else if (now < clock_now)
            st = ST_INVALID;
        else
        begin
            clock_now = now;
            s = find_entry(id);
            if (s < 0)
                st = ST_NOTFOUND;
            else
            begin
                st = ST_OK;
                case (c)
                    CMD_TICK: age_entry(s);
                    CMD_FOCUS:
                        if (t_life[s] == LIFE_CRASHED)
                            st = ST_BADSTATE;
                        else
                        begin
                            if (t_life[s] == LIFE_DISCARDED)
                            begin
                                t_doc[s] = 1'b1;
                                if (t_content[s] == 0)
                                    t_content[s] = RELOAD_SIZE;
                                counters[C_RELOADS]++;
                            end
                            t_life[s] = LIFE_ACTIVE;
                            t_focus[s] = now;
                            focus_holder = id;
                        end
                    CMD_BLUR:
                        if (focus_holder == id)
                            focus_holder = 0;
                    CMD_CRASH:
                        if (t_life[s] == LIFE_CRASHED)
                            st = ST_BADSTATE;
                        else
                        begin
                            t_life[s] = LIFE_CRASHED;
                            t_crashed[s] = 1'b1;
                            counters[C_CRASHES]++;
                            if (focus_holder == id)
                                focus_holder = 0;
                        end
                    CMD_RELOAD:
                        if (t_life[s] != LIFE_CRASHED && t_life[s] != LIFE_DISCARDED)
                            st = ST_INVALID;
                        else
                        begin
                            t_life[s] = LIFE_ACTIVE;
                            t_doc[s] = 1'b1;
                            if (t_content[s] == 0)
                                t_content[s] = RELOAD_SIZE;
                            t_focus[s] = now;
                            counters[C_RELOADS]++;
                            if (t_crashed[s])
                                counters[C_RECOVERIES]++;
                            focus_holder = id;
                        end
                    CMD_DISCARD:
                        if (t_life[s] == LIFE_CRASHED)
                            st = ST_BADSTATE;
                        else
                            drop_doc(s);
                    default: st = ST_INVALID;
                endcase
            end
        end
        a.status = st;
        if (s >= 0)
        begin
            a.tab_state = t_life[s];
            a.content_size = t_content[s];
            a.doc_loaded = t_doc[s];
        end
        a.focused_id = focus_holder;
        a.open_count = in_use;
        a.stat_value = (sel < NSTATS) ? counters[sel] : 32'd0;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a, got;
        if (!rst_n)
        begin
            thr_idle <= 0;
            thr_freeze <= 0;
            thr_discard <= 0;
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                t_used[i] = 0;
                t_id[i] = 0;
                t_life[i] = LIFE_ACTIVE;
                t_focus[i] = 0;
                t_content[i] = 0;
                t_doc[i] = 0;
                t_crashed[i] = 0;
            end
            for (int i = 0; i < NSTATS; i++)
                counters[i] = 0;
            clock_now = 0;
            focus_holder = 0;
            in_use = 0;
            fail_count <= 0;
            answers_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_IDLE: thr_idle <= cfg_data;
                    REG_FREEZE: thr_freeze <= cfg_data;
                    REG_DISCARD: thr_discard <= cfg_data;
                    default: ;
                endcase
            if (done)
            begin
                got = {status, new_id, tab_state, content_size, doc_loaded,
                       focused_id, open_count, stat_value};
                if (answers_due.size() == 0)
                begin
                    $error("result transaction with none expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_a = answers_due.pop_front();
                    if (got != exp_a)
                    begin
                        if (got.status != exp_a.status)
                            $error("status exp %0d got %0d", exp_a.status, got.status);
                        if (got.new_id != exp_a.new_id)
                            $error("new_id exp %0d got %0d", exp_a.new_id, got.new_id);
                        if (got.tab_state != exp_a.tab_state)
                            $error("tab_state exp %0d got %0d",
                                   exp_a.tab_state, got.tab_state);
                        if (got.content_size != exp_a.content_size)
                            $error("content_size exp %0d got %0d",
                                   exp_a.content_size, got.content_size);
                        if (got.doc_loaded != exp_a.doc_loaded)
                            $error("doc_loaded exp %0d got %0d",
                                   exp_a.doc_loaded, got.doc_loaded);
                        if (got.focused_id != exp_a.focused_id)
                            $error("focused_id exp %0d got %0d",
                                   exp_a.focused_id, got.focused_id);
                        if (got.open_count != exp_a.open_count)
                            $error("open_count exp %0d got %0d",
                                   exp_a.open_count, got.open_count);
                        if (got.stat_value != exp_a.stat_value)
                            $error("stat_value exp %0d got %0d",
                                   exp_a.stat_value, got.stat_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Thresholds are read from the registers as they stand before this edge.
            if (start && !busy)
                answers_due.push_back(run_command(cmd, tab_id, content_size_in,
                                                  now_tick, stat_select));
        end
    end
endmodule

// ===== verif/tb_entry_idle_ladder_table.sv =====
`timescale 1ns / 1ps
module tb_entry_idle_ladder_table;
    import eilt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  cmd = CMD_QUERY;
    logic [31:0] tab_id = '0;
    logic [31:0] content_size_in = '0;
    logic [63:0] now_tick = '0;
    logic [2:0]  stat_select = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] new_id;
    logic [2:0]  tab_state;
    logic [31:0] content_size;
    logic        doc_loaded;
    logic [31:0] focused_id;
    logic [4:0]  open_count;
    logic [31:0] stat_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          gap_pct = 0;
    logic [63:0] sim_now = 0;
    logic [31:0] top_id = 0;

    localparam int CYCLE_LIMIT = 400000;

    always #5 clk = ~clk;

    entry_idle_ladder_table DUT (.*);

    eilt_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic issue(int c, logic [31:0] id, logic [31:0] size,
                         logic [63:0] now, int sel);
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct)
            @(posedge clk);
        start <= 1'b1;
        cmd <= 4'(c);
        tab_id <= id;
        content_size_in <= size;
        now_tick <= now;
        stat_select <= 3'(sel);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0)
            return $urandom();
        if (r == 1)
            return 0;
        return (top_id > 20 ? top_id - 20 : 0) + $urandom_range(21, 1);
    endfunction

    task automatic random_phase(int n);
        int r;
        logic [63:0] t;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99, 0);
            if (r < 3)
                t = sim_now - $urandom_range(5, 1);
            else if (r < 5)
                t = {$urandom(), $urandom()};
            else
            begin
                sim_now = sim_now + $urandom_range(200, 0);
                t = sim_now;
            end
            if (t > sim_now && r >= 3)
                sim_now = t;
            r = $urandom_range(99, 0);
            if (r < 18)
            begin
                issue(CMD_OPEN, $urandom(), $urandom(), t, $urandom_range(7, 0));
                top_id = top_id + 1;
            end
            else if (r < 28)
                issue(CMD_CLOSE, pick_id(), $urandom(), t, $urandom_range(7, 0));
            else if (r < 96)
                issue($urandom_range(8, 2), pick_id(), $urandom(), t,
                      $urandom_range(7, 0));
            else
                issue($urandom_range(15, 9), pick_id(), $urandom(), t,
                      $urandom_range(7, 0));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default thresholds, every command and edge case.
        issue(CMD_QUERY, 0, 0, 0, 7);
        issue(CMD_OPEN, 0, 32'hFFFF_FFFF, 0, C_OPENED);
        issue(CMD_OPEN, 0, 0, 0, 7);
        issue(CMD_TICK, 1, 0, 31, C_FREEZES);
        issue(CMD_TICK, 1, 0, 301, C_FREEZES);
        issue(CMD_TICK, 1, 0, 3001, C_DISCARDS);
        issue(CMD_FOCUS, 1, 0, 3002, C_RELOADS);
        issue(CMD_TICK, 2, 0, 10, C_OPENED);
        issue(CMD_CRASH, 2, 0, 3003, C_CRASHES);
        issue(CMD_FOCUS, 2, 0, 3003, C_CRASHES);
        issue(CMD_DISCARD, 2, 0, 3003, C_DISCARDS);
        issue(CMD_CRASH, 2, 0, 3003, C_CRASHES);
        issue(CMD_RELOAD, 1, 0, 3004, C_RELOADS);
        issue(CMD_RELOAD, 2, 0, 3004, C_RECOVERIES);
        issue(CMD_BLUR, 2, 0, 3005, C_OPENED);
        issue(CMD_DISCARD, 1, 0, 3006, C_DISCARDS);
        issue(CMD_RELOAD, 1, 0, 3006, C_RELOADS);
        issue(15, 1, 0, 3007, C_CLOSED);
        issue(CMD_CLOSE, 2, 0, 0, C_CLOSED);
        issue(CMD_OPEN, 0, 5, 0, C_OPENED);
        issue(CMD_CLOSE, 32'hFFFF_FFFF, 0, 0, C_CLOSED);
        issue(CMD_TICK, 3, 0, 64'hFFFF_FFFF_FFFF_FFFF, C_FREEZES);
        issue(CMD_QUERY, 3, 0, 0, C_FREEZES);
        drain();

        // Fresh time base cannot go back, so stay near the top for one short phase.
        write_reg(REG_IDLE, 32'hFFFF_FFFF);
        write_reg(REG_FREEZE, 1);
        write_reg(REG_DISCARD, 0);
        for (int k = 0; k < 16; k++)
            issue(CMD_OPEN, 0, $urandom(), 0, C_OPENED);
        issue(CMD_TICK, 3, 0, 64'hFFFF_FFFF_FFFF_FFFF, C_DISCARDS);
        drain();
        for (int k = 1; k <= 20; k++)
            issue(CMD_CLOSE, k, 0, 0, C_CLOSED);
        drain();
        // Id wrap: a largest id of all ones blocks further opens; the ids here stay far below it.
        top_id = 20;

        // Random phases; time is pinned at its maximum so tick spans use now_tick.
        sim_now = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 36 : (ph == 1) ? 50 : 0;
            write_reg(REG_IDLE, (ph == 0) ? 32'd0 : $urandom_range(50, 1));
            write_reg(REG_FREEZE, (ph == 1) ? 32'd0 : $urandom_range(300, 1));
            write_reg(REG_DISCARD, (ph == 2) ? 32'd1 : $urandom_range(1000, 0));
            random_phase(330);
            drain();
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
design/eilt_pkg.sv
design/eilt_mem.sv
design/entry_idle_ladder_table.sv
verif/eilt_checker.sv
verif/tb_entry_idle_ladder_table.sv
